/* hw/rtl/jdk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdk_pkg
// Shared types, codes and constant tables for the four-way joystick keys.
// ----------------------------------------------------------------------------
package jdk_pkg;

   // Defaults for the top-level parameters
   localparam int CENTER_DEFAULT = 127;
   localparam int LAYER_LIMIT_DEFAULT = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_STEP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_COUNT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINDING_COUNT = 3'd4;
   localparam int CSR_DATA_W = 8;

   // Internal direction codes; the reported code is this value minus one
   localparam logic [2:0] DIR_NONE     = 3'd0;
   localparam logic [2:0] DIR_UP       = 3'd1;
   localparam logic [2:0] DIR_DOWN     = 3'd2;
   localparam logic [2:0] DIR_FORWARD  = 3'd3;
   localparam logic [2:0] DIR_BACKWARD = 3'd4;

   // Result error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_NO_BINDING = 2'd1;
   localparam logic [1:0] ERR_NO_HELD    = 2'd2;

   // Threshold grows by this much while a direction is held
   localparam logic [8:0] HOLD_BONUS = 9'd8;

   // floor(n/1000) == (n * DIV1000_RECIP) >> DIV1000_SHIFT for n < 2**19
   localparam logic [19:0] DIV1000_RECIP = 20'd536871;
   localparam int DIV1000_SHIFT = 29;

   // floor(h*18/10) == (h * 18 * 6554) >> 16 for h*18 < 2**12
   localparam logic [16:0] MARGIN_RECIP = 17'd117972;
   localparam int MARGIN_SHIFT = 16;

   localparam logic signed [10:0] COS_TAB [6] =
      '{11'sd1000, 11'sd1000, 11'sd999, 11'sd999, 11'sd998, 11'sd996};
   localparam logic signed [10:0] SIN_TAB [6] =
      '{11'sd0, 11'sd17, 11'sd35, 11'sd52, 11'sd70, 11'sd87};

   typedef struct packed {
      logic       req_type;
      logic [7:0] sample_value;
      logic [4:0] current_layer;
   } req_item_type;

   typedef struct packed {
      logic       pressed;
      logic [1:0] direction_code;
      logic [6:0] key_index;
      logic [4:0] layer_out;
      logic [1:0] error_code;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]        threshold;
      logic signed [3:0] rotation_step;
      logic [6:0]        hyst_deg;
      logic [5:0]        map_layers;
      logic [7:0]        bind_limit;
   } cfg_type;

   // Values worked out from the registered configuration and registered again
   typedef struct packed {
      logic [16:0] thr_sq;
      logic [16:0] thr_held_sq;
      logic [7:0]  margin;
   } derived_type;

   // Centered pair of samples
   typedef struct packed {
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      logic [4:0]        layer;
   } axis_type;

   // Squared magnitude and rotated numerators (scaled by 1000)
   typedef struct packed {
      logic [16:0]        mag;
      logic signed [19:0] px;
      logic signed [19:0] py;
      logic [4:0]         layer;
   } prod_type;

   // Squared magnitude and rotated vector
   typedef struct packed {
      logic [16:0]       mag;
      logic signed [9:0] rx;
      logic signed [9:0] ry;
      logic [4:0]        layer;
   } rot_type;

   typedef struct packed {
      logic signed [10:0] c;
      logic signed [10:0] s;
   } coef_type;

   // Cosine and sine in thousandths; out-of-range steps mean no rotation
   function automatic coef_type rot_coef(input logic signed [3:0] step);
      logic [3:0] mag;
      coef_type   r;
      mag = step[3] ? 4'(-step) : 4'(step);
      r.c = 11'sd1000;
      r.s = 11'sd0;
      if (mag <= 4'd5) begin
         r.c = COS_TAB[mag[2:0]];
         r.s = step[3] ? -SIN_TAB[mag[2:0]] : SIN_TAB[mag[2:0]];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/jdk_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdk_front
// Input register stage: keeps the latest axis samples and launches a pair.
// ----------------------------------------------------------------------------
module jdk_front #(
   parameter int CENTER_VALUE = jdk_pkg::CENTER_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jdk_pkg::req_item_type req_item,
   output logic                  s1_valid,
   output jdk_pkg::axis_type     s1
);

   logic [7:0]        x_ff, x_in, y_ff, y_in;
   logic              x_fresh_ff, x_fresh_in, y_fresh_ff, y_fresh_in;
   logic              s1_valid_ff, s1_valid_in;
   jdk_pkg::axis_type s1_ff, s1_in;
   logic              accept, trigger;

   assign req_ready = adv;
   assign accept    = req_valid & adv;

   // A fresh flag implies the axis has been seen, so fresh alone gates.
   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      x_fresh_in = x_fresh_ff;
      y_fresh_in = y_fresh_ff;
      if (accept) begin
         if (!req_item.req_type) begin
            x_in       = req_item.sample_value;
            x_fresh_in = 1'b1;
         end else begin
            y_in       = req_item.sample_value;
            y_fresh_in = 1'b1;
         end
      end
      trigger = accept & x_fresh_in & y_fresh_in;
      if (trigger) begin
         x_fresh_in = 1'b0;
         y_fresh_in = 1'b0;
      end
      s1_valid_in = adv ? trigger : s1_valid_ff;
      s1_in.dx    = signed'({1'b0, x_in} - 9'(CENTER_VALUE));
      s1_in.dy    = signed'({1'b0, y_in} - 9'(CENTER_VALUE));
      s1_in.layer = req_item.current_layer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= 8'(CENTER_VALUE);
         y_ff        <= 8'(CENTER_VALUE);
         x_fresh_ff  <= 1'b0;
         y_fresh_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         x_fresh_ff  <= x_fresh_in;
         y_fresh_ff  <= y_fresh_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

/* hw/rtl/jdk_rotate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdk_rotate
// Two stages: squares and rotation products, then truncating divide by 1000.
// ----------------------------------------------------------------------------
module jdk_rotate (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  jdk_pkg::cfg_type  cfg,
   input  logic              s1_valid,
   input  jdk_pkg::axis_type s1,
   output logic              rot_valid,
   output jdk_pkg::rot_type  rot
);

   jdk_pkg::coef_type  coef;
   logic signed [17:0] dxx, dyy;
   logic signed [19:0] dxc, dys, dxs, dyc;
   jdk_pkg::prod_type  s2_ff, s2_in;
   logic               s2_valid_ff;
   logic [18:0]        ax, ay;
   logic [38:0]        qx_prod, qy_prod;
   logic signed [9:0]  qx, qy;
   jdk_pkg::rot_type   s3_ff, s3_in;
   logic               s3_valid_ff;

   // Stage 2: products
   always_comb begin
      coef     = jdk_pkg::rot_coef(cfg.rotation_step);
      dxx      = s1.dx * s1.dx;
      dyy      = s1.dy * s1.dy;
      dxc      = s1.dx * coef.c;
      dys      = s1.dy * coef.s;
      dxs      = s1.dx * coef.s;
      dyc      = s1.dy * coef.c;
      s2_in.mag   = 17'(dxx) + 17'(dyy);
      s2_in.px    = dxc - dys;
      s2_in.py    = dxs + dyc;
      s2_in.layer = s1.layer;
   end

   // Stage 3: divide magnitudes by 1000, then restore sign (toward zero)
   always_comb begin
      ax      = s2_ff.px[19] ? 19'(-s2_ff.px) : s2_ff.px[18:0];
      ay      = s2_ff.py[19] ? 19'(-s2_ff.py) : s2_ff.py[18:0];
      qx_prod = 39'(ax) * 39'(jdk_pkg::DIV1000_RECIP);
      qy_prod = 39'(ay) * 39'(jdk_pkg::DIV1000_RECIP);
      qx      = signed'({1'b0, qx_prod[jdk_pkg::DIV1000_SHIFT +: 9]});
      qy      = signed'({1'b0, qy_prod[jdk_pkg::DIV1000_SHIFT +: 9]});
      s3_in.mag   = s2_ff.mag;
      s3_in.rx    = s2_ff.px[19] ? -qx : qx;
      s3_in.ry    = s2_ff.py[19] ? -qy : qy;
      s3_in.layer = s2_ff.layer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   assign rot_valid = s3_valid_ff;
   assign rot       = s3_ff;

endmodule

/* hw/rtl/jdk_decide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdk_decide
// Direction choice with hysteresis, held-binding state and event results.
// ----------------------------------------------------------------------------
module jdk_decide #(
   parameter int LAYER_LIMIT = jdk_pkg::LAYER_LIMIT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  jdk_pkg::cfg_type      cfg,
   input  jdk_pkg::derived_type  drv,
   input  logic                  rot_valid,
   input  jdk_pkg::rot_type      rot,
   output logic [1:0]            push_cnt,
   output jdk_pkg::rsp_item_type rsp0,
   output jdk_pkg::rsp_item_type rsp1
);

   logic [2:0]         cur_dir_ff, cur_dir_in;
   logic               held_valid_ff, held_valid_in;
   logic [6:0]         held_idx_ff, held_idx_in;
   logic [4:0]         held_layer_ff, held_layer_in;

   logic [16:0]        thr_sq;
   logic               active, keep;
   logic signed [10:0] fwd, side, abs_x, abs_y;
   logic [2:0]         dominant, nd;
   logic               change, rel, rel_fail, press, press_fail, fire;
   logic [4:0]         lay;
   logic [6:0]         idx;
   jdk_pkg::rsp_item_type rel_item, press_item;

   always_comb begin
      thr_sq = (cur_dir_ff != jdk_pkg::DIR_NONE) ? drv.thr_held_sq : drv.thr_sq;
      active = rot.mag >= thr_sq;
      abs_x  = rot.rx[9] ? -11'(rot.rx) : 11'(rot.rx);
      abs_y  = rot.ry[9] ? -11'(rot.ry) : 11'(rot.ry);

      // Forward reach against sideways drift along the held direction
      fwd  = 11'sd0;
      side = 11'sd0;
      case (cur_dir_ff)
         jdk_pkg::DIR_BACKWARD: begin
            fwd  = 11'(rot.rx);
            side = abs_y;
         end
         jdk_pkg::DIR_FORWARD: begin
            fwd  = -11'(rot.rx);
            side = abs_y;
         end
         jdk_pkg::DIR_DOWN: begin
            fwd  = 11'(rot.ry);
            side = abs_x;
         end
         jdk_pkg::DIR_UP: begin
            fwd  = -11'(rot.ry);
            side = abs_x;
         end
         default: begin
            fwd  = 11'sd0;
            side = 11'sd0;
         end
      endcase
      keep = (cur_dir_ff != jdk_pkg::DIR_NONE) && (fwd > 11'sd0)
             && (fwd >= side - signed'({3'b000, drv.margin}));

      if (abs_x >= abs_y) begin
         dominant = rot.rx[9] ? jdk_pkg::DIR_FORWARD : jdk_pkg::DIR_BACKWARD;
      end else begin
         dominant = rot.ry[9] ? jdk_pkg::DIR_UP : jdk_pkg::DIR_DOWN;
      end

      if (!active) begin
         nd = jdk_pkg::DIR_NONE;
      end else if (keep) begin
         nd = cur_dir_ff;
      end else begin
         nd = dominant;
      end

      // Layer without a mapping falls back to layer zero
      if (({1'b0, rot.layer} >= cfg.map_layers) ||
          ({1'b0, rot.layer} >= 6'(LAYER_LIMIT))) begin
         lay = 5'd0;
      end else begin
         lay = rot.layer;
      end
      idx = {lay, 2'(nd - 3'd1)};

      change     = rot_valid && (nd != cur_dir_ff);
      rel        = cur_dir_ff != jdk_pkg::DIR_NONE;
      rel_fail   = !held_valid_ff || ({1'b0, held_idx_ff} >= cfg.bind_limit);
      press      = nd != jdk_pkg::DIR_NONE;
      press_fail = {1'b0, idx} >= cfg.bind_limit;
      fire       = change && adv;

      rel_item.pressed        = 1'b0;
      rel_item.direction_code = 2'(cur_dir_ff - 3'd1);
      rel_item.key_index      = rel_fail ? 7'd0 : held_idx_ff;
      rel_item.layer_out      = held_layer_ff;
      rel_item.error_code     = rel_fail ? jdk_pkg::ERR_NO_HELD : jdk_pkg::ERR_NONE;
      rel_item.last           = rel_fail || !press;

      press_item.pressed        = 1'b1;
      press_item.direction_code = 2'(nd - 3'd1);
      press_item.key_index      = idx;
      press_item.layer_out      = lay;
      press_item.error_code     = press_fail ? jdk_pkg::ERR_NO_BINDING : jdk_pkg::ERR_NONE;
      press_item.last           = 1'b1;

      rsp0 = rel ? rel_item : press_item;
      rsp1 = press_item;

      push_cnt      = 2'd0;
      cur_dir_in    = cur_dir_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      held_layer_in = held_layer_ff;
      if (fire) begin
         if (rel && rel_fail) begin
            // Failed release: report and keep everything as it was
            push_cnt = 2'd1;
         end else begin
            push_cnt = 2'(rel) + 2'(press);
            if (rel) begin
               held_valid_in = 1'b0;
            end
            cur_dir_in = nd;
            if (press) begin
               if (press_fail) begin
                  cur_dir_in = jdk_pkg::DIR_NONE;
               end else begin
                  held_valid_in = 1'b1;
                  held_idx_in   = idx;
                  held_layer_in = lay;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_dir_ff    <= jdk_pkg::DIR_NONE;
         held_valid_ff <= 1'b0;
         held_idx_ff   <= 7'd0;
         held_layer_ff <= 5'd0;
      end else begin
         cur_dir_ff    <= cur_dir_in;
         held_valid_ff <= held_valid_in;
         held_idx_ff   <= held_idx_in;
         held_layer_ff <= held_layer_in;
      end
   end

   // Nothing is held while no direction is active
   a_none_not_held: assert property (@(posedge clock) disable iff (reset)
      (cur_dir_ff == jdk_pkg::DIR_NONE) |-> !held_valid_ff)
      else $error("binding held with no direction");

   // A successful press leaves its binding held
   a_press_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && !(rel && rel_fail) && press && !press_fail)
      |=> (held_valid_ff && (cur_dir_ff != jdk_pkg::DIR_NONE)))
      else $error("press did not hold binding");

   // Last flag sits on the final result of a pair
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (push_cnt == 2'd2) |-> (!rsp0.last && rsp1.last))
      else $error("last flag misplaced");

endmodule

/* hw/rtl/jdk_rsp_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdk_rsp_fifo
// Four-entry result queue; takes up to two items a cycle, gives one while rsp_ready is high.
// ----------------------------------------------------------------------------
module jdk_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  jdk_pkg::rsp_item_type push0,
   input  jdk_pkg::rsp_item_type push1,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jdk_pkg::rsp_item_type rsp_item
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   jdk_pkg::rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;
   logic                  pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_item  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;
   assign room      = count_ff <= (PTR_W+1)'(DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("push without room");

   a_push_cnt: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 2'd3)
      else $error("bad push count");

endmodule

/* hw/rtl/joystick_four_way_direction_keys.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_four_way_direction_keys
// Four-way joystick direction keys with threshold and angular hysteresis.
// ----------------------------------------------------------------------------
// Path: a sample that completes an X/Y pair passes the input reg, products
//   and divide registers; decide then writes the result queue, which gives
//   its first result item.
// Throughput: one input item per cycle unless the pipe stalls; results leave
//   one per cycle while taken, so an item that releases and presses yields two.
// Reset (synchronous, active high): config registers return to defaults, no
//   direction held, both axes at center and not fresh, result queue empty.
// ----------------------------------------------------------------------------
module joystick_four_way_direction_keys #(
   parameter int CENTER_VALUE = jdk_pkg::CENTER_DEFAULT,
   parameter int LAYER_LIMIT  = jdk_pkg::LAYER_LIMIT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  jdk_pkg::req_item_type              req_item,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output jdk_pkg::rsp_item_type              rsp_item,
   // configuration writes
   input  logic                               csr_we,
   input  logic [jdk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jdk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   jdk_pkg::cfg_type      cfg_ff, cfg_in;
   jdk_pkg::derived_type  drv_ff, drv_in;
   logic [8:0]            thr, thr_held;
   logic [23:0]           margin_prod;

   logic                  adv, room;
   logic                  s1_valid, rot_valid;
   jdk_pkg::axis_type     s1;
   jdk_pkg::rot_type      rot;
   logic [1:0]            push_cnt;
   jdk_pkg::rsp_item_type rsp0, rsp1;

   // Configuration registers: to be written only while the block is idle.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            jdk_pkg::CSR_THRESHOLD:     cfg_in.threshold     = csr_wdata;
            jdk_pkg::CSR_ROTATION_STEP: cfg_in.rotation_step = signed'(csr_wdata[3:0]);
            jdk_pkg::CSR_HYSTERESIS:    cfg_in.hyst_deg      = csr_wdata[6:0];
            jdk_pkg::CSR_LAYER_COUNT:   cfg_in.map_layers    = csr_wdata[5:0];
            jdk_pkg::CSR_BINDING_COUNT: cfg_in.bind_limit    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold     <= 8'd32;
         cfg_ff.rotation_step <= 4'sd0;
         cfg_ff.hyst_deg      <= 7'd0;
         cfg_ff.map_layers    <= 6'd1;
         cfg_ff.bind_limit    <= 8'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Squared thresholds (normal and while held) and the angular margin,
   // registered off the config so the compare path stays short.
   always_comb begin
      thr              = {1'b0, cfg_ff.threshold};
      thr_held         = thr + jdk_pkg::HOLD_BONUS;
      drv_in.thr_sq      = 17'(thr) * 17'(thr);
      drv_in.thr_held_sq = 17'(thr_held) * 17'(thr_held);
      // margin = hysteresis * 18 / 10 via reciprocal multiply
      margin_prod      = 24'(cfg_ff.hyst_deg) * 24'(jdk_pkg::MARGIN_RECIP);
      drv_in.margin      = margin_prod[jdk_pkg::MARGIN_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      drv_ff <= drv_in;
   end

   // The whole pipe moves together; it stalls only when the decision stage
   // holds a pair and the result queue lacks room for two items.
   assign adv = !rot_valid || room;

   jdk_front #(
      .CENTER_VALUE (CENTER_VALUE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .s1_valid  (s1_valid),
      .s1        (s1)
   );

   jdk_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .s1_valid  (s1_valid),
      .s1        (s1),
      .rot_valid (rot_valid),
      .rot       (rot)
   );

   jdk_decide #(
      .LAYER_LIMIT (LAYER_LIMIT)
   ) u_decide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .drv       (drv_ff),
      .rot_valid (rot_valid),
      .rot       (rot),
      .push_cnt  (push_cnt),
      .rsp0      (rsp0),
      .rsp1      (rsp1)
   );

   jdk_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push0     (rsp0),
      .push1     (rsp1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
